### rtl/lcbc_pkg.sv
// Shared constants, types and helpers for the Luhn card brand checker.
package lcbc_pkg;

    // Input and decimal geometry
    localparam int unsigned NUM_BITS       = 54;
    localparam int unsigned NUM_DIGITS     = 17;
    localparam int unsigned BCD_W          = 4 * NUM_DIGITS;
    localparam int unsigned CNT_W          = 5;

    // Binary to BCD pipeline: BITS_PER_STAGE shift/adjust steps per stage
    localparam int unsigned BITS_PER_STAGE = 3;
    localparam int unsigned NUM_STAGES     = NUM_BITS / BITS_PER_STAGE;
    localparam int unsigned TAIL_STAGES    = 3;
    localparam int unsigned LATENCY        = NUM_STAGES + TAIL_STAGES;

    // Digit sum tree
    localparam int unsigned GRP_SIZE       = 4;
    localparam int unsigned NUM_GROUPS     = (NUM_DIGITS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int unsigned GRP_W          = 6;
    localparam int unsigned SUM_W          = 8;

    // Longest number that may carry a brand
    localparam int unsigned MAX_DIGITS     = 16;

    // Branded lengths and prefix digits
    localparam logic [CNT_W-1:0] LEN_VISA_SHORT = 5'd13;
    localparam logic [CNT_W-1:0] LEN_AMEX       = 5'd15;
    localparam logic [CNT_W-1:0] LEN_LONG       = 5'd16;
    localparam logic [3:0]       PFX_AMEX_HI    = 4'd3;
    localparam logic [3:0]       PFX_AMEX_LO_A  = 4'd4;
    localparam logic [3:0]       PFX_AMEX_LO_B  = 4'd7;
    localparam logic [3:0]       PFX_MC_HI      = 4'd5;
    localparam logic [3:0]       PFX_VISA_HI    = 4'd4;

    typedef logic [BCD_W-1:0]    t_bcd;
    typedef logic [NUM_BITS-1:0] t_bin;

    typedef enum logic [1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_AMEX       = 2'd1,
        BRAND_MASTERCARD = 2'd2,
        BRAND_VISA       = 2'd3
    } t_brand;

    // Luhn weight of one digit: doubled ones fold their two digits
    function automatic logic [3:0] luhn_map(input logic [3:0] d, input logic dbl);
        logic [4:0] twice;
        twice = {d, 1'b0};
        if (!dbl) begin
            return d;
        end else if (twice > 5'd9) begin
            return 4'(twice - 5'd9);
        end else begin
            return twice[3:0];
        end
    endfunction

endpackage

### rtl/lcbc_dd_stage.sv
// One registered stage of the shift-and-add-3 binary to BCD converter.
module lcbc_dd_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lcbc_pkg::t_bcd     i_bcd,
    input  lcbc_pkg::t_bin     i_bin,
    output logic               o_valid,
    output lcbc_pkg::t_bcd     o_bcd,
    output lcbc_pkg::t_bin     o_bin
);

    logic           r_valid;
    lcbc_pkg::t_bcd r_bcd;
    lcbc_pkg::t_bin r_bin;
    lcbc_pkg::t_bcd n_bcd;
    lcbc_pkg::t_bin n_bin;

    // Adjust every digit of 5 or more by 3, then shift the next bit in
    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < lcbc_pkg::BITS_PER_STAGE; s++) begin
            for (int k = 0; k < lcbc_pkg::NUM_DIGITS; k++) begin
                if (n_bcd[4*k +: 4] >= 4'd5) begin
                    n_bcd[4*k +: 4] = n_bcd[4*k +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[lcbc_pkg::BCD_W-2:0], n_bin[lcbc_pkg::NUM_BITS-1]};
            n_bin = {n_bin[lcbc_pkg::NUM_BITS-2:0], 1'b0};
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_bin <= n_bin;
    end

    assign o_valid = r_valid;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;

endmodule

### rtl/luhn_card_brand_check.sv
// Top level: Luhn mod 10 check, digit count and card brand of a binary card number.
//
//  channel  | direction | handshake                | beat contents
//  ---------+-----------+--------------------------+-------------------------------------
//  command  | in        | start high, busy low     | i_card_number
//  result   | out       | o_result_valid, 1 cycle  | o_brand, o_luhn_ok, o_digit_count
//
//  The input passes through 18 stages of binary to BCD conversion (three bits per
//  stage over the 54-bit input), then digit sum and count, total sum, and the
//  check/brand stage. A new beat may enter every cycle.
//  Synchronous active-low reset clears all valid bits; busy is high only in reset.
//  The receiver cannot stall, so the pipeline never holds.
module luhn_card_brand_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [53:0]                  i_card_number,
    output logic                         o_result_valid,
    output logic [1:0]                   o_brand,
    output logic                         o_luhn_ok,
    output logic [4:0]                   o_digit_count
);

    localparam int unsigned NS = lcbc_pkg::NUM_STAGES;
    localparam int unsigned NG = lcbc_pkg::NUM_GROUPS;

    logic                 r_busy;
    logic                 accept;

    logic                 stg_valid [0:NS];
    lcbc_pkg::t_bcd       stg_bcd   [0:NS];
    lcbc_pkg::t_bin       stg_bin   [0:NS];

    // Tail stage 1: group sums, count, leading digits
    logic                            r_s1_valid;
    logic [lcbc_pkg::GRP_W-1:0]      r_s1_grp [0:NG-1];
    logic [lcbc_pkg::GRP_W-1:0]      n_s1_grp [0:NG-1];
    logic [lcbc_pkg::CNT_W-1:0]      r_s1_cnt, n_s1_cnt;
    logic [3:0]                      r_s1_hi, n_s1_hi;
    logic [3:0]                      r_s1_lo, n_s1_lo;

    // Tail stage 2: total sum
    logic                            r_s2_valid;
    logic [lcbc_pkg::SUM_W-1:0]      r_s2_sum, n_s2_sum;
    logic [lcbc_pkg::CNT_W-1:0]      r_s2_cnt;
    logic [3:0]                      r_s2_hi, r_s2_lo;

    // Tail stage 3: remainder check and brand
    logic                            r_out_valid;
    logic [1:0]                      r_brand;
    logic                            r_ok;
    logic [lcbc_pkg::CNT_W-1:0]      r_cnt;
    logic [15:0]                     prod;
    logic [4:0]                      quot;
    logic [lcbc_pkg::SUM_W-1:0]      quot_x10;
    logic [lcbc_pkg::SUM_W-1:0]      rem;
    logic                            n_ok;
    lcbc_pkg::t_brand                n_brand;

    // Command handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // Binary to BCD pipeline
    assign stg_valid[0] = accept;
    assign stg_bcd[0]   = '0;
    assign stg_bin[0]   = i_card_number;

    for (genvar g = 0; g < NS; g++) begin : g_dd
        lcbc_dd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .i_bcd   (stg_bcd[g]),
            .i_bin   (stg_bin[g]),
            .o_valid (stg_valid[g+1]),
            .o_bcd   (stg_bcd[g+1]),
            .o_bin   (stg_bin[g+1])
        );
    end

    // Luhn weights summed in groups; count from the highest non-zero digit
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_s1_grp[g] = '0;
        end
        n_s1_cnt = '0;
        for (int k = 0; k < lcbc_pkg::NUM_DIGITS; k++) begin
            n_s1_grp[k/lcbc_pkg::GRP_SIZE] = n_s1_grp[k/lcbc_pkg::GRP_SIZE]
                + {2'b00, lcbc_pkg::luhn_map(stg_bcd[NS][4*k +: 4], (k % 2) == 1)};
            if (stg_bcd[NS][4*k +: 4] != 4'd0) begin
                n_s1_cnt = 5'(k + 1);
            end
        end
        // Leading two digits, only needed for branded lengths
        case (n_s1_cnt)
            lcbc_pkg::LEN_VISA_SHORT: begin
                n_s1_hi = stg_bcd[NS][4*12 +: 4];
                n_s1_lo = stg_bcd[NS][4*11 +: 4];
            end
            lcbc_pkg::LEN_AMEX: begin
                n_s1_hi = stg_bcd[NS][4*14 +: 4];
                n_s1_lo = stg_bcd[NS][4*13 +: 4];
            end
            lcbc_pkg::LEN_LONG: begin
                n_s1_hi = stg_bcd[NS][4*15 +: 4];
                n_s1_lo = stg_bcd[NS][4*14 +: 4];
            end
            default: begin
                n_s1_hi = 4'd0;
                n_s1_lo = 4'd0;
            end
        endcase
    end

    // Total of the group sums
    always_comb begin
        n_s2_sum = '0;
        for (int g = 0; g < NG; g++) begin
            n_s2_sum = n_s2_sum + {2'b00, r_s1_grp[g]};
        end
    end

    // Sum mod 10 through a reciprocal multiply (exact over the whole 8-bit sum range)
    always_comb begin
        prod     = {8'd0, r_s2_sum} * 16'd205;
        quot     = prod[15:11];
        quot_x10 = {3'd0, quot} * 8'd10;
        rem      = r_s2_sum - quot_x10;
        n_ok     = (rem == '0);
    end

    // Brand decode
    always_comb begin
        n_brand = lcbc_pkg::BRAND_INVALID;
        if (n_ok && r_s2_cnt != '0 && r_s2_cnt <= 5'(lcbc_pkg::MAX_DIGITS)) begin
            case (r_s2_cnt)
                lcbc_pkg::LEN_AMEX: begin
                    if (r_s2_hi == lcbc_pkg::PFX_AMEX_HI &&
                        (r_s2_lo == lcbc_pkg::PFX_AMEX_LO_A ||
                         r_s2_lo == lcbc_pkg::PFX_AMEX_LO_B)) begin
                        n_brand = lcbc_pkg::BRAND_AMEX;
                    end
                end
                lcbc_pkg::LEN_LONG: begin
                    if (r_s2_hi == lcbc_pkg::PFX_MC_HI && r_s2_lo inside {[4'd1:4'd5]}) begin
                        n_brand = lcbc_pkg::BRAND_MASTERCARD;
                    end else if (r_s2_hi == lcbc_pkg::PFX_VISA_HI) begin
                        n_brand = lcbc_pkg::BRAND_VISA;
                    end
                end
                lcbc_pkg::LEN_VISA_SHORT: begin
                    if (r_s2_hi == lcbc_pkg::PFX_VISA_HI) begin
                        n_brand = lcbc_pkg::BRAND_VISA;
                    end
                end
                default: begin
                    n_brand = lcbc_pkg::BRAND_INVALID;
                end
            endcase
        end
    end

    // Tail valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= stg_valid[NS];
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Tail payload
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NG; g++) begin
            r_s1_grp[g] <= n_s1_grp[g];
        end
        r_s1_cnt <= n_s1_cnt;
        r_s1_hi  <= n_s1_hi;
        r_s1_lo  <= n_s1_lo;
        r_s2_sum <= n_s2_sum;
        r_s2_cnt <= r_s1_cnt;
        r_s2_hi  <= r_s1_hi;
        r_s2_lo  <= r_s1_lo;
        r_brand  <= n_brand;
        r_ok     <= n_ok;
        r_cnt    <= r_s2_cnt;
    end

    assign o_result_valid = r_out_valid;
    assign o_brand        = r_brand;
    assign o_luhn_ok      = r_ok;
    assign o_digit_count  = r_cnt;

`ifndef SYNTH
    // Every accepted beat comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(lcbc_pkg::LATENCY) o_result_valid)
        else $error("result beat missing after pipeline latency");

    // A failed checksum never carries a brand
    a_no_brand_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_luhn_ok) |-> (o_brand == lcbc_pkg::BRAND_INVALID))
        else $error("brand given with failed checksum");

    // Amex only on 15 digits
    a_amex_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_brand == lcbc_pkg::BRAND_AMEX)
            |-> (o_digit_count == lcbc_pkg::LEN_AMEX))
        else $error("amex brand with wrong length");

    // Visa only on 13 or 16 digits
    a_visa_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_brand == lcbc_pkg::BRAND_VISA)
            |-> (o_digit_count == lcbc_pkg::LEN_VISA_SHORT ||
                 o_digit_count == lcbc_pkg::LEN_LONG))
        else $error("visa brand with wrong length");

    // A 54-bit value never has more than 17 digits
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_digit_count <= 5'(lcbc_pkg::NUM_DIGITS)))
        else $error("digit count out of range");
`endif

endmodule
